@@ rtl/ipv4_longest_prefix_route_table_macros.svh @@
// ---------------------------------------------------------------------------
// Route table assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef IPV4_LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define ROUTE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ROUTE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ROUTE_ASSERT_ALWAYS(label, expr, msg)
`define ROUTE_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

@@ rtl/lpmrt_pkg.sv @@
// ---------------------------------------------------------------------------
// Route table package
// Shared constants, codes, entry types and the prefix mask function.
// ---------------------------------------------------------------------------
package lpmrt_pkg;

  localparam int ENTRIES    = 16;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ADDR_W     = 32;
  localparam int PFX_W      = 6;
  localparam int IF_W       = 4;
  localparam int FLAG_W     = 8;
  localparam int MAX_PREFIX = 32;

  localparam logic [2:0] ACT_ADD        = 3'd0;
  localparam logic [2:0] ACT_REMOVE     = 3'd1;
  localparam logic [2:0] ACT_PURGE_IF   = 3'd2;
  localparam logic [2:0] ACT_PURGE_DHCP = 3'd3;
  localparam logic [2:0] ACT_LOOKUP     = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ARG     = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_NOMATCH = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_UPDATE,
    CMD_INSERT,
    CMD_DELETE
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] gw;
    logic [PFX_W-1:0]  prefix;
    logic [FLAG_W-1:0] flags;
    logic [IF_W-1:0]   itf;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [PFX_W-1:0]  prefix;
    logic [ADDR_W-1:0] gw;
    logic [IF_W-1:0]   itf;
    logic [FLAG_W-1:0] flags;
  } item_t;

  typedef struct packed {
    cmd_t cmd;
    logic sel;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic same;
    logic purge;
    logic keep;
  } cell_stat_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] p);
    return ~({ADDR_W{1'b1}} >> p);
  endfunction

endpackage

@@ rtl/lpmrt_cell.sv @@
// ---------------------------------------------------------------------------
// Route table cell
// Holds one route, compares it against the current transaction and takes
// its next value from itself, the new route or a neighbouring cell.
// ---------------------------------------------------------------------------
module lpmrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lpmrt_pkg::item_t     item,
  input  logic                 dhcp_only,
  input  logic [7:0]           dhcp_mask,
  input  lpmrt_pkg::cell_ctrl_t ctrl,
  input  logic                 prev_keep,
  input  lpmrt_pkg::entry_t    prev_entry,
  input  lpmrt_pkg::entry_t    next_entry,
  output lpmrt_pkg::entry_t    entry,
  output lpmrt_pkg::cell_stat_t stat
);
  import lpmrt_pkg::*;

  logic              valid;
  logic [ADDR_W-1:0] own_mask;
  logic [ADDR_W-1:0] item_mask;
  entry_t            new_entry;
  entry_t            entry_next;

  assign valid     = (entry.itf != '0);
  assign own_mask  = prefix_mask(entry.prefix);
  assign item_mask = prefix_mask(item.prefix);

  assign stat.hit   = valid && ((item.dest & own_mask) == (entry.dest & own_mask));
  assign stat.same  = valid && (entry.prefix == item.prefix) &&
                      ((entry.dest & item_mask) == (item.dest & item_mask)) &&
                      ((item.itf == '0) || (entry.itf == item.itf));
  assign stat.purge = valid && (entry.itf == item.itf) &&
                      (!dhcp_only || ((entry.flags & dhcp_mask) != '0));
  assign stat.keep  = valid && (entry.prefix >= item.prefix);

  assign new_entry.dest   = item.dest & item_mask;
  assign new_entry.gw     = item.gw;
  assign new_entry.prefix = item.prefix;
  assign new_entry.flags  = item.flags;
  assign new_entry.itf    = item.itf;

  always_comb begin
    entry_next = entry;
    case (ctrl.cmd)
      CMD_UPDATE: begin
        if (ctrl.sel) begin
          entry_next.gw    = item.gw;
          entry_next.flags = item.flags;
        end
      end
      CMD_INSERT: begin
        if (!stat.keep) begin
          entry_next = prev_keep ? new_entry : prev_entry;
        end
      end
      CMD_DELETE: begin
        if (ctrl.shift) begin
          entry_next = next_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

@@ rtl/ipv4_longest_prefix_route_table.sv @@
// ---------------------------------------------------------------------------
// IPv4 longest prefix route table
// Sequencing: a transaction is accepted in the idle state and executed in
// the execute state, where its result is registered onto the output.
// Interface and DHCP removal stay in the execute state and delete one
// matching route at a time; a result held on the output stalls the final
// step. A new transaction is taken only once the last result is registered.
// Reset empties the table and sets the DHCP flag mask to 1.
// ---------------------------------------------------------------------------
`include "ipv4_longest_prefix_route_table_macros.svh"

module ipv4_longest_prefix_route_table (
  input  logic        clk,
  input  logic        rst,
  // Input tdata fields from bit 0: dest_addr, prefix_length, gateway_addr,
  // interface_id, route_flags, zero padding.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,
  // Input tuser fields from bit 0: action.
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Output tdata fields from bit 0: hit_gateway, hit_interface, hit_flags,
  // hit_prefix, route_count, zero padding.
  output logic [55:0] m_tdata,
  // Output tuser fields from bit 0: status, hit.
  output logic [2:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import lpmrt_pkg::*;

  state_t          state;
  state_t          state_next;
  item_t           item;
  logic [2:0]      action;
  logic [7:0]      dhcp_mask;
  logic [CNT_W-1:0] route_count;
  logic [CNT_W-1:0] count_next;

  entry_t          entries [ENTRIES];
  cell_stat_t      stats   [ENTRIES];
  cell_ctrl_t      ctrls   [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] same_vec;
  logic [ENTRIES-1:0] purge_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [ENTRIES-1:0] from_first;
  logic               any;
  logic               finish;
  logic               out_free;
  logic               go;
  logic               dhcp_only;
  cmd_t               cmd;
  logic [1:0]         status;
  entry_t             hit_entry;
  logic               hit;
  logic               full_out;

  assign cfg_ready = 1'b1;
  assign dhcp_only = (action == ACT_PURGE_DHCP);

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic   prev_keep;
      entry_t prev_entry;
      entry_t next_entry;

      if (g == 0) begin : g_first
        assign prev_keep  = 1'b1;
        assign prev_entry = '0;
      end else begin : g_mid
        assign prev_keep  = stats[g-1].keep;
        assign prev_entry = entries[g-1];
      end

      if (g == ENTRIES - 1) begin : g_last
        assign next_entry = '0;
      end else begin : g_body
        assign next_entry = entries[g+1];
      end

      assign ctrls[g].cmd   = go ? cmd : CMD_HOLD;
      assign ctrls[g].sel   = first[g];
      assign ctrls[g].shift = from_first[g];

      lpmrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .item       (item),
        .dhcp_only  (dhcp_only),
        .dhcp_mask  (dhcp_mask),
        .ctrl       (ctrls[g]),
        .prev_keep  (prev_keep),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .entry      (entries[g]),
        .stat       (stats[g])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = stats[i].hit;
      same_vec[i]  = stats[i].same;
      purge_vec[i] = stats[i].purge;
      valid_vec[i] = (entries[i].itf != '0);
    end
  end

  always_comb begin
    match      = '0;
    cmd        = CMD_HOLD;
    status     = STATUS_OK;
    count_next = route_count;
    finish     = 1'b1;
    case (action)
      ACT_ADD: begin
        match = same_vec;
        if ((item.itf == '0) || (item.prefix > PFX_W'(MAX_PREFIX))) begin
          status = STATUS_ARG;
        end else if (|same_vec) begin
          cmd = CMD_UPDATE;
        end else if (route_count == CNT_W'(ENTRIES)) begin
          status = STATUS_FULL;
        end else begin
          cmd        = CMD_INSERT;
          count_next = route_count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        match = same_vec;
        if (item.prefix > PFX_W'(MAX_PREFIX)) begin
          status = STATUS_ARG;
        end else if (|same_vec) begin
          cmd        = CMD_DELETE;
          count_next = route_count - CNT_W'(1);
        end else begin
          status = STATUS_NOMATCH;
        end
      end
      ACT_PURGE_IF, ACT_PURGE_DHCP: begin
        match = purge_vec;
        if (item.itf == '0) begin
          status = STATUS_ARG;
        end else if (|purge_vec) begin
          cmd        = CMD_DELETE;
          count_next = route_count - CNT_W'(1);
          finish     = 1'b0;
        end
      end
      ACT_LOOKUP: begin
        match = hit_vec;
        if (!(|hit_vec)) begin
          status = STATUS_NOMATCH;
        end
      end
      default: status = STATUS_ARG;
    endcase
  end

  assign any        = |match;
  assign first      = match & (~match + ENTRIES'(1));
  assign from_first = ~(first - ENTRIES'(1));
  assign out_free   = !m_tvalid || m_tready;
  assign go         = (state == ST_EXEC) && (out_free || !finish);
  assign hit        = (action == ACT_LOOKUP) && any;
  assign full_out   = m_tvalid && (m_tuser[1:0] == STATUS_FULL);

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_entry = hit_entry | (first[i] ? entries[i] : '0);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go && finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      route_count <= '0;
      dhcp_mask   <= 8'd1;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        dhcp_mask <= cfg_data;
      end
      if (go) begin
        route_count <= count_next;
      end
      if (go && finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.dest   <= s_tdata[31:0];
      item.prefix <= s_tdata[37:32];
      item.gw     <= s_tdata[69:38];
      item.itf    <= s_tdata[73:70];
      item.flags  <= s_tdata[81:74];
      action      <= s_tuser;
    end
    if (go && finish) begin
      m_tuser <= {hit, status};
      if (hit) begin
        m_tdata <= {1'b0, count_next, hit_entry.prefix, hit_entry.flags,
                    hit_entry.itf, hit_entry.gw};
      end else begin
        m_tdata <= {1'b0, count_next, {(PFX_W + FLAG_W + IF_W + ADDR_W){1'b0}}};
      end
    end
  end

  `ROUTE_ASSERT_ALWAYS(a_count_range, route_count <= CNT_W'(ENTRIES), "route count too high")
  `ROUTE_ASSERT_ALWAYS(a_count_matches, CNT_W'($countones(valid_vec)) == route_count, "bad count")
  `ROUTE_ASSERT_ALWAYS(a_packed, (valid_vec & (valid_vec + ENTRIES'(1))) == '0, "gap in table")
  `ROUTE_ASSERT_IMPLY(a_full_status, full_out, m_tdata[54:50] == CNT_W'(ENTRIES), "full with room")
  `ROUTE_ASSERT_IMPLY(a_hit_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == STATUS_OK, "hit not ok")

endmodule
